>>> hdl/clnw_pkg.sv
// clnw_pkg: shared types, codes and the microcode table of the lcd nibble writer
`timescale 1ns / 1ps

package clnw_pkg;

  typedef enum logic [2:0] {
    OP_CMD    = 3'd0,
    OP_CHR    = 3'd1,
    OP_INIT   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_NUMBER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SRC_OPB   = 2'd0,
    SRC_CONST = 2'd1,
    SRC_DIGIT = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_END      = 2'd1,
    J_LOOP     = 2'd2,
    J_LOOP_END = 2'd3
  } jump_t;

  localparam int PC_W  = 5;
  localparam int CNT_W = 4;

  localparam logic [PC_W-1:0] ENTRY_CMD  = 5'd0;
  localparam logic [PC_W-1:0] ENTRY_CHR  = 5'd2;
  localparam logic [PC_W-1:0] ENTRY_INIT = 5'd4;
  localparam logic [PC_W-1:0] ENTRY_NUM  = 5'd24;
  localparam logic [PC_W-1:0] ENTRY_DIG  = 5'd25;
  localparam logic [PC_W-1:0] LAST_INIT  = 5'd23;

  localparam logic [CNT_W-1:0] DABBLE_CNT = 4'd15;
  localparam logic [CNT_W-1:0] DIGIT_CNT  = 4'd4;

  localparam logic [7:0] CLEAR_CMD   = 8'h01;
  localparam logic [7:0] CURSOR_ROW0 = 8'h80;
  localparam logic [7:0] CURSOR_ROW1 = 8'hC0;
  localparam logic [3:0] ASCII_DIGIT = 4'h3;
  localparam logic [3:0] INIT_PREWAIT = 4'd15;

  localparam logic [7:0] INIT_BYTES [10] = '{
    8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h06, 8'h0c, 8'h03, 8'h80, 8'h01
  };
  localparam logic [3:0] INIT_WAIT [10] = '{
    4'd2, 4'd2, 4'd6, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3
  };

  typedef struct packed {
    logic             emit;
    src_t             src;
    logic             lower;
    logic             rs;
    logic [3:0]       wb;
    logic [3:0]       wa;
    logic             clr_chk;
    logic             dabble;
    logic             digit_shift;
    jump_t            jump;
    logic [PC_W-1:0]  target;
    logic [CNT_W-1:0] cnt_init;
    logic [7:0]       const_byte;
  } ctrl_word_t;

  typedef struct packed {
    logic active;
    logic ending;
  } seq_stat_t;

  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_word_t      cw;
    logic [PC_W-1:0] k;
    cw = '0;
    cw.src  = SRC_OPB;
    cw.jump = J_END;
    k = pc - ENTRY_INIT;
    if (pc >= ENTRY_INIT && pc <= LAST_INIT) begin
      // init: ten constant command bytes, upper then lower nibble
      cw.emit       = 1'b1;
      cw.src        = SRC_CONST;
      cw.lower      = k[0];
      cw.const_byte = INIT_BYTES[k[4:1]];
      cw.wb         = (pc == ENTRY_INIT) ? INIT_PREWAIT : 4'd0;
      cw.wa         = k[0] ? INIT_WAIT[k[4:1]] : 4'd0;
      cw.jump       = (pc == LAST_INIT) ? J_END : J_NEXT;
    end else begin
      unique case (pc)
        ENTRY_CMD: begin
          cw.emit = 1'b1;
          cw.jump = J_NEXT;
        end
        ENTRY_CMD + 5'd1: begin
          cw.emit    = 1'b1;
          cw.lower   = 1'b1;
          cw.wa      = 4'd1;
          cw.clr_chk = 1'b1;
          cw.jump    = J_END;
        end
        ENTRY_CHR: begin
          cw.emit = 1'b1;
          cw.rs   = 1'b1;
          cw.jump = J_NEXT;
        end
        ENTRY_CHR + 5'd1: begin
          cw.emit  = 1'b1;
          cw.rs    = 1'b1;
          cw.lower = 1'b1;
          cw.wa    = 4'd1;
          cw.jump  = J_END;
        end
        ENTRY_NUM: begin
          // binary to bcd, one shift-and-adjust per step
          cw.dabble   = 1'b1;
          cw.jump     = J_LOOP;
          cw.target   = ENTRY_NUM;
          cw.cnt_init = DIGIT_CNT;
        end
        ENTRY_DIG: begin
          cw.emit = 1'b1;
          cw.src  = SRC_DIGIT;
          cw.rs   = 1'b1;
          cw.jump = J_NEXT;
        end
        ENTRY_DIG + 5'd1: begin
          cw.emit        = 1'b1;
          cw.src         = SRC_DIGIT;
          cw.rs          = 1'b1;
          cw.lower       = 1'b1;
          cw.wa          = 4'd1;
          cw.digit_shift = 1'b1;
          cw.jump        = J_LOOP_END;
          cw.target      = ENTRY_DIG;
        end
        default: cw.jump = J_END;
      endcase
    end
    return cw;
  endfunction

endpackage

>>> hdl/char_lcd_nibble_writer_core.sv
// char_lcd_nibble_writer_core: top level of the 4-bit character lcd bus writer
`timescale 1ns / 1ps

// usage:
// an operation is taken at a rising edge with start high and busy low; opcode
// selects command byte, character byte, init, set cursor or print number,
// the other fields carry its operands.
// each resulting bus pulse appears on nibble, reg_select, wait_before_ms,
// wait_after_ms and last for exactly one cycle, marked by strobe; last flags
// the final beat of the operation.
// a microcoded sequencer steps one table word per cycle; every emit step
// gives one beat, so the beats of consecutive emit steps come one per cycle,
// each through the strobe register. command, character and set cursor each
// send one byte, upper nibble first; init sends ten command bytes; print
// number does 16 bcd conversion steps, then 10 beats. unused opcodes are
// not taken and emit nothing. busy falls with the final step, so the next
// operation may start while the last beat is still on the ports.
// the receiver cannot stall; beats are never held back.
// reset is synchronous: it stops any sequence in progress and clears strobe.

module char_lcd_nibble_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  row,
  input  logic [3:0]  column,
  input  logic [15:0] number,
  output logic        strobe,
  output logic [3:0]  nibble,
  output logic        reg_select,
  output logic [3:0]  wait_before_ms,
  output logic [3:0]  wait_after_ms,
  output logic        last
);

  logic                       go;
  logic                       known_op;
  logic [clnw_pkg::PC_W-1:0]  entry;
  logic [clnw_pkg::CNT_W-1:0] cnt_start;
  logic [7:0]                 opb_in;
  clnw_pkg::ctrl_word_t       cw;
  clnw_pkg::seq_stat_t        stat;

  always_comb begin
    known_op  = 1'b1;
    entry     = clnw_pkg::ENTRY_CMD;
    cnt_start = '0;
    opb_in    = byte_value;
    unique case (opcode)
      clnw_pkg::OP_CMD:  entry = clnw_pkg::ENTRY_CMD;
      clnw_pkg::OP_CHR:  entry = clnw_pkg::ENTRY_CHR;
      clnw_pkg::OP_INIT: entry = clnw_pkg::ENTRY_INIT;
      clnw_pkg::OP_CURSOR: begin
        // cursor address goes out as an ordinary command byte
        entry  = clnw_pkg::ENTRY_CMD;
        opb_in = ((row <= 8'd1) ? clnw_pkg::CURSOR_ROW0 : clnw_pkg::CURSOR_ROW1)
                 | {4'h0, column};
      end
      clnw_pkg::OP_NUMBER: begin
        entry     = clnw_pkg::ENTRY_NUM;
        cnt_start = clnw_pkg::DABBLE_CNT;
      end
      default: known_op = 1'b0;
    endcase
  end

  assign busy = stat.active;
  assign go   = start && !busy && known_op;

  clnw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .entry     (entry),
    .cnt_start (cnt_start),
    .cw        (cw),
    .stat      (stat)
  );

  clnw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .opb_in         (opb_in),
    .number_in      (number),
    .cw             (cw),
    .stat           (stat),
    .strobe         (strobe),
    .nibble         (nibble),
    .reg_select     (reg_select),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

endmodule

>>> hdl/clnw_seq.sv
// clnw_seq: step counter, loop counter and microcode lookup
`timescale 1ns / 1ps

module clnw_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [clnw_pkg::PC_W-1:0]    entry,
  input  logic [clnw_pkg::CNT_W-1:0]   cnt_start,
  output clnw_pkg::ctrl_word_t         cw,
  output clnw_pkg::seq_stat_t          stat
);

  logic                       active;
  logic [clnw_pkg::PC_W-1:0]  pc;
  logic [clnw_pkg::CNT_W-1:0] cnt;
  logic                       cnt_zero;

  assign cw       = clnw_pkg::rom_word(pc);
  assign cnt_zero = (cnt == '0);

  always_comb begin
    stat.active = active;
    stat.ending = active && ((cw.jump == clnw_pkg::J_END) ||
                             (cw.jump == clnw_pkg::J_LOOP_END && cnt_zero));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pc     <= '0;
      cnt    <= '0;
    end else if (go) begin
      active <= 1'b1;
      pc     <= entry;
      cnt    <= cnt_start;
    end else if (active) begin
      case (cw.jump)
        clnw_pkg::J_NEXT: pc <= pc + 1'b1;
        clnw_pkg::J_END:  active <= 1'b0;
        clnw_pkg::J_LOOP: begin
          if (!cnt_zero) begin
            cnt <= cnt - 1'b1;
            pc  <= cw.target;
          end else begin
            cnt <= cw.cnt_init;
            pc  <= pc + 1'b1;
          end
        end
        default: begin
          if (!cnt_zero) begin
            cnt <= cnt - 1'b1;
            pc  <= cw.target;
          end else begin
            active <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

>>> hdl/clnw_dp.sv
// clnw_dp: operand registers, bcd converter and the registered bus pulse
`timescale 1ns / 1ps

module clnw_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [7:0]            opb_in,
  input  logic [15:0]           number_in,
  input  clnw_pkg::ctrl_word_t  cw,
  input  clnw_pkg::seq_stat_t   stat,
  output logic                  strobe,
  output logic [3:0]            nibble,
  output logic                  reg_select,
  output logic [3:0]            wait_before_ms,
  output logic [3:0]            wait_after_ms,
  output logic                  last
);

  logic [7:0]  opb;
  logic [15:0] bin;
  logic [19:0] bcd;
  logic [19:0] bcd_adj;
  logic [7:0]  pulse_byte;
  logic [3:0]  wa_eff;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < 5; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3
                                                   : bcd[d*4 +: 4];
    end
  end

  always_comb begin
    case (cw.src)
      clnw_pkg::SRC_CONST: pulse_byte = cw.const_byte;
      clnw_pkg::SRC_DIGIT: pulse_byte = {clnw_pkg::ASCII_DIGIT, bcd[19:16]};
      default:             pulse_byte = opb;
    endcase
    wa_eff = cw.wa + ((cw.clr_chk && opb == clnw_pkg::CLEAR_CMD) ? 4'd2 : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      opb <= opb_in;
      bin <= number_in;
      bcd <= '0;
    end else if (stat.active && cw.dabble) begin
      {bcd, bin} <= {bcd_adj[18:0], bin, 1'b0};
    end else if (stat.active && cw.digit_shift) begin
      bcd <= {bcd[15:0], 4'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= stat.active && cw.emit;
    end
  end

  always_ff @(posedge clk) begin
    nibble         <= cw.lower ? pulse_byte[3:0] : pulse_byte[7:4];
    reg_select     <= cw.rs;
    wait_before_ms <= cw.wb;
    wait_after_ms  <= wa_eff;
    last           <= stat.ending;
  end

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for the 4-bit character lcd nibble writer
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_OPS = 230;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // expected bus beats, built from each accepted operation
  class lcd_beat_book;
    typedef struct packed {
      logic [3:0] nib;
      logic       rs;
      logic [3:0] wb;
      logic [3:0] wa;
      logic       fin;
    } beat_t;

    beat_t pending[$];

    function void push_byte(logic [7:0] b, logic rs, logic [3:0] wb, logic [3:0] wa);
      beat_t hi;
      beat_t lo;
      hi = '{nib: b[7:4], rs: rs, wb: wb, wa: 4'd0, fin: 1'b0};
      lo = '{nib: b[3:0], rs: rs, wb: 4'd0, wa: wa, fin: 1'b0};
      pending.push_back(hi);
      pending.push_back(lo);
    endfunction

    // commands wait 1 ms, a clear waits 2 ms more
    function void push_cmd(logic [7:0] b, logic [3:0] wb, logic [3:0] extra);
      push_byte(b, 1'b0, wb,
                4'd1 + extra + ((b == clnw_pkg::CLEAR_CMD) ? 4'd2 : 4'd0));
    endfunction

    function void note_op(logic [2:0] op, logic [7:0] bv, logic [7:0] r,
                          logic [3:0] c, logic [15:0] n);
      logic [7:0] boot_bytes [10];
      logic [3:0] boot_pad [10];
      int before_cnt;
      int div;
      boot_bytes = '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h06, 8'h0c, 8'h03, 8'h80, 8'h01};
      boot_pad = '{4'd1, 4'd1, 4'd5, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
      before_cnt = pending.size();
      case (op)
        clnw_pkg::OP_CMD: push_cmd(bv, 4'd0, 4'd0);
        clnw_pkg::OP_CHR: push_byte(bv, 1'b1, 4'd0, 4'd1);
        clnw_pkg::OP_INIT: begin
          for (int i = 0; i < 10; i++)
            push_cmd(boot_bytes[i], (i == 0) ? 4'd15 : 4'd0, boot_pad[i]);
        end
        clnw_pkg::OP_CURSOR: begin
          push_cmd(((r <= 8'd1) ? clnw_pkg::CURSOR_ROW0 : clnw_pkg::CURSOR_ROW1)
                   | {4'h0, c}, 4'd0, 4'd0);
        end
        clnw_pkg::OP_NUMBER: begin
          div = 10000;
          for (int i = 0; i < 5; i++) begin
            push_byte(8'((n / div) % 10 + 48), 1'b1, 4'd0, 4'd1);
            div = div / 10;
          end
        end
        default: ;
      endcase
      if (pending.size() > before_cnt) pending[$].fin = 1'b1;
    endfunction

    // empty string means the beat matched
    function string check_beat(logic [3:0] nib, logic rs, logic [3:0] wb,
                               logic [3:0] wa, logic fin);
      beat_t want;
      string msg;
      if (pending.size() == 0)
        return $sformatf("unexpected beat nibble=%h rs=%b wb=%0d wa=%0d last=%b",
                         nib, rs, wb, wa, fin);
      want = pending.pop_front();
      msg = "";
      if (nib !== want.nib) msg = {msg, $sformatf(" nibble %h/%h", nib, want.nib)};
      if (rs !== want.rs) msg = {msg, $sformatf(" reg_select %b/%b", rs, want.rs)};
      if (wb !== want.wb) msg = {msg, $sformatf(" wait_before %0d/%0d", wb, want.wb)};
      if (wa !== want.wa) msg = {msg, $sformatf(" wait_after %0d/%0d", wa, want.wa)};
      if (fin !== want.fin) msg = {msg, $sformatf(" last %b/%b", fin, want.fin)};
      if (msg != "") msg = {"beat got/want:", msg};
      return msg;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  opcode = '0;
  logic [7:0]  byte_value = '0;
  logic [7:0]  row = '0;
  logic [3:0]  column = '0;
  logic [15:0] number = '0;
  logic        busy;
  logic        strobe;
  logic [3:0]  nibble;
  logic        reg_select;
  logic [3:0]  wait_before_ms;
  logic [3:0]  wait_after_ms;
  logic        last;

  lcd_beat_book sb;
  int mismatches = 0;
  int idle_cycles = 0;

  char_lcd_nibble_writer_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .byte_value     (byte_value),
    .row            (row),
    .column         (column),
    .number         (number),
    .strobe         (strobe),
    .nibble         (nibble),
    .reg_select     (reg_select),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // operation beat: pre-edge values of start, busy and operands
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_op(opcode, byte_value, row, column, number);
  end

  always @(posedge clk) begin : beat_mon
    string msg;
    if (!rst && strobe) begin
      msg = sb.check_beat(nibble, reg_select, wait_before_ms, wait_after_ms, last);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // called right after a rising edge; returns gap edges after busy is first seen low
  task automatic issue(input logic [2:0] op, input logic [7:0] bv, input logic [7:0] r,
                       input logic [3:0] c, input logic [15:0] n, input int gap);
    opcode     <= op;
    byte_value <= bv;
    row        <= r;
    column     <= c;
    number     <= n;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // mostly back to back or short, now and then a long pause
  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : stim
    int done_ops;
    int burst;
    int p;
    logic [2:0]  op;
    logic [7:0]  r;
    logic [15:0] n;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, clear, every row class, column ends, digit extremes
    issue(clnw_pkg::OP_CMD, 8'h01, 8'h00, 4'h0, 16'h0000, 0);
    issue(clnw_pkg::OP_CMD, 8'h00, 8'hff, 4'hf, 16'hffff, 0);
    issue(clnw_pkg::OP_CMD, 8'hff, 8'h00, 4'h0, 16'h0000, 1);
    issue(clnw_pkg::OP_CMD, 8'h02, 8'h55, 4'h5, 16'h5555, 0);
    issue(clnw_pkg::OP_CHR, 8'h00, 8'h00, 4'h0, 16'h0000, 0);
    issue(clnw_pkg::OP_CHR, 8'hff, 8'hff, 4'hf, 16'hffff, 2);
    issue(clnw_pkg::OP_CHR, 8'h01, 8'haa, 4'ha, 16'haaaa, 0);
    issue(clnw_pkg::OP_INIT, 8'h00, 8'h00, 4'h0, 16'h0000, 0);
    issue(clnw_pkg::OP_CURSOR, 8'h00, 8'd0, 4'd0, 16'h0000, 0);
    issue(clnw_pkg::OP_CURSOR, 8'hff, 8'd1, 4'd15, 16'hffff, 3);
    issue(clnw_pkg::OP_CURSOR, 8'h00, 8'd2, 4'd5, 16'h0000, 0);
    issue(clnw_pkg::OP_CURSOR, 8'h00, 8'd255, 4'd15, 16'h0000, 0);
    issue(clnw_pkg::OP_NUMBER, 8'h00, 8'h00, 4'h0, 16'd0, 0);
    issue(clnw_pkg::OP_NUMBER, 8'hff, 8'hff, 4'hf, 16'd65535, 0);
    issue(clnw_pkg::OP_NUMBER, 8'h00, 8'h00, 4'h0, 16'd10000, 1);
    issue(clnw_pkg::OP_NUMBER, 8'h00, 8'h00, 4'h0, 16'd9, 0);
    issue(clnw_pkg::OP_NUMBER, 8'h00, 8'h00, 4'h0, 16'd40960, 0);
    issue(OP_SPARE_LO, 8'hff, 8'hff, 4'hf, 16'hffff, 0);
    issue(OP_SPARE_MID, 8'h00, 8'h00, 4'h0, 16'h0000, 0);
    issue(OP_SPARE_HI, 8'h5a, 8'h01, 4'h3, 16'h1234, 0);
    issue(clnw_pkg::OP_INIT, 8'hff, 8'hff, 4'hf, 16'hffff, 1);

    // hold off until the bus is quiet before the random part
    drain();

    done_ops = 0;
    burst = 0;
    while (done_ops < RANDOM_OPS) begin
      p = $urandom_range(0, 99);
      if (p < 24) op = clnw_pkg::OP_CMD;
      else if (p < 48) op = clnw_pkg::OP_CHR;
      else if (p < 54) op = clnw_pkg::OP_INIT;
      else if (p < 70) op = clnw_pkg::OP_CURSOR;
      else if (p < 92) op = clnw_pkg::OP_NUMBER;
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      r = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      n = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 99)) : 16'($urandom);
      if (done_ops % 60 == 30) burst = 20;
      issue(op, 8'($urandom), r, 4'($urandom), n,
            (burst > 0 || done_ops == RANDOM_OPS - 1) ? 1 - ((burst > 0) ? 1 : 0)
                                                     : sender_gap());
      if (burst > 0) burst--;
      if (op <= clnw_pkg::OP_NUMBER) done_ops++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) report($sformatf("%0d beats never came", sb.pending.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
